### hdl/msac_pkg.sv
`timescale 1ns / 1ps
package msac_pkg;

   // Configuration register indexes.
   localparam logic [7:0] CFG_COS   = 8'd0;
   localparam logic [7:0] CFG_SIN   = 8'd1;
   localparam logic [7:0] CFG_TRX   = 8'd2;
   localparam logic [7:0] CFG_TRY   = 8'd3;
   localparam logic [7:0] CFG_TRZ   = 8'd4;
   localparam logic [7:0] CFG_THR   = 8'd5;
   localparam int         CFG_COUNT = 6;

   localparam logic [31:0] COS_RESET = 32'h4000_0000;
   localparam logic [31:0] THR_RESET = 32'd196608;

   localparam int DEF_MAX_CONSTRAINTS = 4096;
   localparam int INDEX_W = 12;

   localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [30:0] DIFF_CAP = 31'h7FFF_FFFF;

   typedef logic signed [31:0] q30_type;

   // Limit a yaw term to plus or minus one in Q2.30.
   function automatic q30_type clamp_q30(input logic signed [31:0] v);
      q30_type r;
      if (v > 32'sh4000_0000) begin
         r = 32'sh4000_0000;
      end else if (v < -32'sh4000_0000) begin
         r = -32'sh4000_0000;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Magnitude of a 32-bit signed value; the most negative value fits unsigned.
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic signed [32:0] w;
      w = {v[31], v};
      if (v < 0) begin
         w = -w;
      end
      return w[31:0];
   endfunction

   // Magnitude of an axis difference, capped at 2^31-1.
   function automatic logic [30:0] cap_mag(input logic signed [37:0] d);
      logic signed [37:0] a;
      logic [30:0] r;
      a = (d < 0) ? -d : d;
      if (a > 38'sd2147483647) begin
         r = DIFF_CAP;
      end else begin
         r = a[30:0];
      end
      return r;
   endfunction

endpackage

### hdl/msac_ifs.sv
`timescale 1ns / 1ps
interface msac_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] tag_x;
   logic signed [31:0] tag_y;
   logic signed [31:0] tag_z;
   logic signed [31:0] anchor_x;
   logic signed [31:0] anchor_y;
   logic signed [31:0] anchor_z;
   logic [31:0]        measured_range;
   logic [31:0]        range_deviation;
   logic               final_item;
   modport source (output valid, tag_x, tag_y, tag_z, anchor_x, anchor_y, anchor_z,
                   measured_range, range_deviation, final_item, input ready);
   modport sink (input valid, tag_x, tag_y, tag_z, anchor_x, anchor_y, anchor_z,
                 measured_range, range_deviation, final_item, output ready);
endinterface

interface msac_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] constraint_index;
   logic        is_inlier;
   logic [31:0] residual_sq;
   logic [47:0] total_cost;
   logic        set_done;
   modport source (output valid, constraint_index, is_inlier, residual_sq, total_cost,
                   set_done, input ready);
   modport sink (input valid, constraint_index, is_inlier, residual_sq, total_cost,
                 set_done, output ready);
endinterface

interface msac_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/msac_mul.sv
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle.
module msac_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [63:0] product
);
   logic [31:0] hi_ff, hi_in;
   logic [31:0] lo_ff, lo_in;
   logic [31:0] a_ff, a_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] sum;

   // Add the multiplicand when the low bit is set, then shift the pair right.
   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sum     = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : 33'd0);
      if (start) begin
         hi_in   = '0;
         lo_in   = b;
         a_in    = a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = sum[32:1];
         lo_in  = {sum[0], lo_ff[31:1]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};
endmodule

### hdl/msac_sqrt.sv
`timescale 1ns / 1ps
// Restoring integer square root: two radicand bits per cycle.
module msac_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] xs_ff, xs_in;
   logic [34:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [35:0] rem_t;
   logic [35:0] trial;

   // Bring down two bits and try to subtract four times the root plus one.
   always_comb begin
      xs_in   = xs_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_t   = {rem_ff[33:0], xs_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         xs_in   = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         xs_in  = {xs_ff[61:0], 2'b00};
         cnt_in = cnt_ff + 5'd1;
         if (rem_t >= trial) begin
            rem_in  = 35'(rem_t - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_t[34:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      xs_ff   <= xs_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

### hdl/msac_range_residual_scorer_unit.sv
`timescale 1ns / 1ps
// Scores one yaw and translation hypothesis against a stream of range
// constraints and returns one result beat per request beat, with the running
// MSAC cost. Each item is taken from its request beat, then uses nine 32-bit
// products on one shift-add multiplier, a square root and a 48-bit restoring
// division, and its result is then posted. Posting waits while the previous
// result is still unclaimed. One item is in work at a time; a finished result
// waits in an output register, so the next request beat is taken while the
// previous result is still unclaimed. The user must write configuration only
// while the block is idle; the block itself does not enforce it.
module msac_range_residual_scorer_unit #(
   parameter int MAX_CONSTRAINTS = msac_pkg::DEF_MAX_CONSTRAINTS
) (
   input  logic       clock,
   input  logic       reset,
   msac_req_if.sink   req_bus,
   msac_rsp_if.source rsp_bus,
   msac_csr_if.sink   csr_bus
);
   localparam int CNT_W = $clog2(MAX_CONSTRAINTS);
   localparam int PAD_W = 17 - CNT_W;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LAUNCH = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_POST   = 3'd5;

   localparam logic [3:0] OP_CTX = 4'd0;
   localparam logic [3:0] OP_STY = 4'd1;
   localparam logic [3:0] OP_STX = 4'd2;
   localparam logic [3:0] OP_CTY = 4'd3;
   localparam logic [3:0] OP_DX  = 4'd4;
   localparam logic [3:0] OP_DY  = 4'd5;
   localparam logic [3:0] OP_DZ  = 4'd6;
   localparam logic [3:0] OP_E   = 4'd7;
   localparam logic [3:0] OP_TAU = 4'd8;

   // Configuration registers.
   logic [31:0] cfg_ff [msac_pkg::CFG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[msac_pkg::CFG_COS[2:0]] <= msac_pkg::COS_RESET;
         cfg_ff[msac_pkg::CFG_SIN[2:0]] <= '0;
         cfg_ff[msac_pkg::CFG_TRX[2:0]] <= '0;
         cfg_ff[msac_pkg::CFG_TRY[2:0]] <= '0;
         cfg_ff[msac_pkg::CFG_TRZ[2:0]] <= '0;
         cfg_ff[msac_pkg::CFG_THR[2:0]] <= msac_pkg::THR_RESET;
      end else if (csr_bus.valid && (csr_bus.index < 8'(msac_pkg::CFG_COUNT))) begin
         cfg_ff[3'(csr_bus.index)] <= csr_bus.data;
      end
   end
   assign csr_bus.ready = 1'b1;

   msac_pkg::q30_type cos_c, sin_c;
   assign cos_c = msac_pkg::clamp_q30(cfg_ff[msac_pkg::CFG_COS[2:0]]);
   assign sin_c = msac_pkg::clamp_q30(cfg_ff[msac_pkg::CFG_SIN[2:0]]);

   // Control and item registers.
   logic [2:0]         state_ff, state_in;
   logic [3:0]         op_ff, op_in;
   logic signed [31:0] tx_ff, ty_ff, ax_ff, ay_ff;
   logic [31:0]        meas_ff, dev_ff;
   logic               fin_ff;
   logic [30:0]        dxm_ff, dxm_in, dym_ff, dym_in, dzm_ff, dzm_in;
   logic signed [65:0] acc_ff, acc_in;
   logic [63:0]        sumsq_ff, sumsq_in;
   logic [47:0]        q_ff, q_in;
   logic [31:0]        rem_ff, rem_in;
   logic [5:0]         dcnt_ff, dcnt_in;
   logic [47:0]        e2_ff, e2_in;
   logic [47:0]        tau2_ff, tau2_in;
   logic [47:0]        cost_ff, cost_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [msac_pkg::INDEX_W-1:0] o_idx_ff, o_idx_in;
   logic               o_inl_ff, o_inl_in;
   logic [31:0]        o_res_ff, o_res_in;
   logic [47:0]        o_cost_ff, o_cost_in;
   logic               o_done_ff, o_done_in;

   logic               req_fire;
   logic               mul_start, mul_done, root_start, root_done;
   logic [31:0]        mul_a, mul_b, root_out;
   logic               mul_neg;
   logic [63:0]        mul_p;
   logic signed [64:0] sp;
   logic signed [65:0] rsum;
   logic signed [35:0] rot;
   logic signed [37:0] dz_full, dxy_full;
   logic [32:0]        rt;
   logic               dev_zero, e_over, inl, out_free;
   logic [47:0]        e2_eff, add;
   logic [48:0]        cost_sum;
   logic [16:0]        cnt_pad;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (op_ff)
         OP_CTX: begin
            mul_a = msac_pkg::mag32(cos_c); mul_b = msac_pkg::mag32(tx_ff);
            mul_neg = cos_c[31] ^ tx_ff[31];
         end
         OP_STY: begin
            mul_a = msac_pkg::mag32(sin_c); mul_b = msac_pkg::mag32(ty_ff);
            mul_neg = sin_c[31] ^ ty_ff[31];
         end
         OP_STX: begin
            mul_a = msac_pkg::mag32(sin_c); mul_b = msac_pkg::mag32(tx_ff);
            mul_neg = sin_c[31] ^ tx_ff[31];
         end
         OP_CTY: begin
            mul_a = msac_pkg::mag32(cos_c); mul_b = msac_pkg::mag32(ty_ff);
            mul_neg = cos_c[31] ^ ty_ff[31];
         end
         OP_DX: begin
            mul_a = {1'b0, dxm_ff}; mul_b = {1'b0, dxm_ff};
         end
         OP_DY: begin
            mul_a = {1'b0, dym_ff}; mul_b = {1'b0, dym_ff};
         end
         OP_DZ: begin
            mul_a = {1'b0, dzm_ff}; mul_b = {1'b0, dzm_ff};
         end
         OP_E: begin
            mul_a = q_ff[31:0]; mul_b = q_ff[31:0];
         end
         OP_TAU: begin
            mul_a = cfg_ff[msac_pkg::CFG_THR[2:0]]; mul_b = cfg_ff[msac_pkg::CFG_THR[2:0]];
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign mul_start  = (state_ff == ST_LAUNCH);
   assign sp         = mul_neg ? -$signed({1'b0, mul_p}) : $signed({1'b0, mul_p});

   msac_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   msac_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (sumsq_ff),
      .done     (root_done),
      .root     (root_out)
   );

   // Rounded rotation term and the translated axis difference.
   always_comb begin
      if (op_ff == OP_STY) begin
         rsum = acc_ff - 66'(sp) + 66'sd536870912;
      end else begin
         rsum = acc_ff + 66'(sp) + 66'sd536870912;
      end
      rot = 36'(rsum >>> 30);
      if (op_ff == OP_STY) begin
         dxy_full = 38'(rot) + 38'(signed'(cfg_ff[msac_pkg::CFG_TRX[2:0]])) - 38'(ax_ff);
      end else begin
         dxy_full = 38'(rot) + 38'(signed'(cfg_ff[msac_pkg::CFG_TRY[2:0]])) - 38'(ay_ff);
      end
      dz_full = 38'(req_bus.tag_z) + 38'(signed'(cfg_ff[msac_pkg::CFG_TRZ[2:0]]))
                - 38'(req_bus.anchor_z);
   end

   // Division step.
   assign rt       = {rem_ff, q_ff[47]};
   assign dev_zero = (dev_ff == '0);
   assign e_over   = |q_ff[47:32];

   // Final scoring.
   always_comb begin
      e2_eff   = (dev_zero || e_over) ? msac_pkg::MASK48 : e2_ff;
      inl      = !dev_zero && (e2_eff < tau2_ff);
      add      = inl ? e2_eff : tau2_ff;
      cost_sum = {1'b0, cost_ff} + {1'b0, add};
      cnt_pad  = {{PAD_W{1'b0}}, cnt_ff};
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      dxm_in       = dxm_ff;
      dym_in       = dym_ff;
      dzm_in       = dzm_ff;
      acc_in       = acc_ff;
      sumsq_in     = sumsq_ff;
      q_in         = q_ff;
      rem_in       = rem_ff;
      dcnt_in      = dcnt_ff;
      e2_in        = e2_ff;
      tau2_in      = tau2_ff;
      cost_in      = cost_ff;
      cnt_in       = cnt_ff;
      root_start   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_idx_in     = o_idx_ff;
      o_inl_in     = o_inl_ff;
      o_res_in     = o_res_ff;
      o_cost_in    = o_cost_ff;
      o_done_in    = o_done_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               dzm_in   = msac_pkg::cap_mag(dz_full);
               op_in    = OP_CTX;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mul_done) begin
               op_in    = op_ff + 4'd1;
               state_in = ST_LAUNCH;
               unique case (op_ff)
                  OP_CTX, OP_STX: acc_in = 66'(sp);
                  OP_STY: dxm_in = msac_pkg::cap_mag(dxy_full);
                  OP_CTY: dym_in = msac_pkg::cap_mag(dxy_full);
                  OP_DX: sumsq_in = mul_p;
                  OP_DY: sumsq_in = sumsq_ff + mul_p;
                  OP_DZ: begin
                     sumsq_in   = sumsq_ff + mul_p;
                     state_in   = ST_ROOT;
                  end
                  OP_E: e2_in = mul_p[63:16];
                  OP_TAU: begin
                     tau2_in  = mul_p[63:16];
                     state_in = ST_POST;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_ROOT: begin
            root_start = (op_ff == OP_E);
            op_in      = OP_DX;
            if (root_done) begin
               state_in = ST_DIV;
               dcnt_in  = '0;
               rem_in   = '0;
               q_in     = {(root_out >= meas_ff) ? root_out - meas_ff
                                                 : meas_ff - root_out, 16'd0};
            end
         end
         ST_DIV: begin
            dcnt_in = dcnt_ff + 6'd1;
            if (rt >= {1'b0, dev_ff}) begin
               rem_in = 32'(rt - {1'b0, dev_ff});
               q_in   = {q_ff[46:0], 1'b1};
            end else begin
               rem_in = rt[31:0];
               q_in   = {q_ff[46:0], 1'b0};
            end
            if (dcnt_ff == 6'd47) begin
               op_in    = OP_E;
               state_in = ST_LAUNCH;
            end
         end
         ST_POST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_idx_in     = cnt_pad[msac_pkg::INDEX_W-1:0];
               o_inl_in     = inl;
               o_res_in     = (|e2_eff[47:32]) ? 32'hFFFF_FFFF : e2_eff[31:0];
               o_cost_in    = cost_sum[48] ? msac_pkg::MASK48 : cost_sum[47:0];
               o_done_in    = fin_ff;
               if (fin_ff) begin
                  cost_in = '0;
                  cnt_in  = '0;
               end else begin
                  cost_in = cost_sum[48] ? msac_pkg::MASK48 : cost_sum[47:0];
                  cnt_in  = (cnt_ff == CNT_W'(MAX_CONSTRAINTS - 1)) ? '0
                                                                    : cnt_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         tx_ff   <= req_bus.tag_x;
         ty_ff   <= req_bus.tag_y;
         ax_ff   <= req_bus.anchor_x;
         ay_ff   <= req_bus.anchor_y;
         meas_ff <= req_bus.measured_range;
         dev_ff  <= req_bus.range_deviation;
         fin_ff  <= req_bus.final_item;
      end
      dxm_ff    <= dxm_in;
      dym_ff    <= dym_in;
      dzm_ff    <= dzm_in;
      acc_ff    <= acc_in;
      sumsq_ff  <= sumsq_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      dcnt_ff   <= dcnt_in;
      e2_ff     <= e2_in;
      tau2_ff   <= tau2_in;
      o_idx_ff  <= o_idx_in;
      o_inl_ff  <= o_inl_in;
      o_res_ff  <= o_res_in;
      o_cost_ff <= o_cost_in;
      o_done_ff <= o_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_CTX;
         cost_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cost_ff      <= cost_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.constraint_index = o_idx_ff;
   assign rsp_bus.is_inlier        = o_inl_ff;
   assign rsp_bus.residual_sq      = o_res_ff;
   assign rsp_bus.total_cost       = o_cost_ff;
   assign rsp_bus.set_done         = o_done_ff;

`ifndef SYNTHESIS
   // A final beat clears the running cost and index right after it is posted.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && out_free && fin_ff) |=> (cost_ff == '0 && cnt_ff == '0))
      else $error("cost or index not cleared after final beat");
   // An inlier that carries the saturated residual never has an empty cost.
   a_inlier_res: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && o_inl_ff) |-> (o_res_ff != 32'hFFFF_FFFF || o_cost_ff != '0))
      else $error("inlier with saturated residual and empty cost");
   // The set index stays below MAX_CONSTRAINTS.
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (17'(cnt_ff) < 17'(MAX_CONSTRAINTS)))
      else $error("constraint counter out of range");
   // A new request is only taken while idle, and it moves the sequencer to launch.
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_LAUNCH))
      else $error("request accepted outside idle");
`endif
endmodule

### sim/tb_msac_scoreboard.sv
`timescale 1ns / 1ps
// Predicts one result beat per accepted constraint and checks the result stream.
class msac_cost_scoreboard;
   logic signed [31:0] cos_yaw, sin_yaw, trans_x, trans_y, trans_z;
   logic [31:0]        threshold;
   logic [47:0]        cost_sum;
   logic [11:0]        item_count;
   logic [11:0]        exp_index[$];
   logic               exp_inlier[$];
   logic [31:0]        exp_resid[$];
   logic [47:0]        exp_cost[$];
   logic               exp_done[$];
   int                 errors;

   function new();
      cos_yaw = msac_pkg::COS_RESET;
      sin_yaw = 0;
      trans_x = 0;
      trans_y = 0;
      trans_z = 0;
      threshold = msac_pkg::THR_RESET;
      cost_sum = 0;
      item_count = 0;
      errors = 0;
   endfunction

   function void write_reg(logic [7:0] idx, logic [31:0] val);
      case (idx)
         msac_pkg::CFG_COS: cos_yaw = val;
         msac_pkg::CFG_SIN: sin_yaw = val;
         msac_pkg::CFG_TRX: trans_x = val;
         msac_pkg::CFG_TRY: trans_y = val;
         msac_pkg::CFG_TRZ: trans_z = val;
         msac_pkg::CFG_THR: threshold = val;
         default: ;
      endcase
   endfunction

   // Integer square root, floor.
   function logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Axis difference capped in magnitude, then squared.
   function logic [63:0] axis_sq(longint d);
      longint m;
      m = d < 0 ? -d : d;
      if (m > 64'sd2147483647) m = 64'sd2147483647;
      return m * m;
   endfunction

   // Accepted constraint beat: compute expected result and advance state.
   function void note_constraint(logic signed [31:0] tx, ty, tz, ax, ay, az,
                                 logic [31:0] meas, dev, logic fin);
      longint c, s, rx, ry, dx, dy, dz;
      logic [63:0] tau2, pred, num, e, e2, cost;
      logic inl;
      c = cos_yaw;
      s = sin_yaw;
      if (c > 64'sd1073741824) c = 64'sd1073741824;
      if (c < -64'sd1073741824) c = -64'sd1073741824;
      if (s > 64'sd1073741824) s = 64'sd1073741824;
      if (s < -64'sd1073741824) s = -64'sd1073741824;
      tau2 = ({32'd0, threshold} * {32'd0, threshold}) >> 16;
      rx = (c * longint'(tx) - s * longint'(ty) + (64'sd1 << 29)) >>> 30;
      ry = (s * longint'(tx) + c * longint'(ty) + (64'sd1 << 29)) >>> 30;
      dx = rx + longint'(trans_x) - longint'(ax);
      dy = ry + longint'(trans_y) - longint'(ay);
      dz = longint'(tz) + longint'(trans_z) - longint'(az);
      pred = root_floor(axis_sq(dx) + axis_sq(dy) + axis_sq(dz));
      num = meas >= pred ? meas - pred : pred - meas;
      if (dev == 0) begin
         e2 = msac_pkg::MASK48;
         inl = 1'b0;
      end else begin
         e = (num << 16) / dev;
         if (e >= 64'h1_0000_0000) begin
            e2 = msac_pkg::MASK48;
         end else begin
            e2 = (e * e) >> 16;
            if (e2 > msac_pkg::MASK48) e2 = msac_pkg::MASK48;
         end
         inl = e2 < tau2;
      end
      cost = cost_sum + (inl ? e2 : tau2);
      if (cost > msac_pkg::MASK48) cost = msac_pkg::MASK48;
      exp_index.insert(exp_index.size(), item_count);
      exp_inlier.insert(exp_inlier.size(), inl);
      exp_resid.insert(exp_resid.size(), e2 > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : e2[31:0]);
      exp_cost.insert(exp_cost.size(), cost[47:0]);
      exp_done.insert(exp_done.size(), fin);
      if (fin) begin
         cost_sum = 0;
         item_count = 0;
      end else begin
         cost_sum = cost[47:0];
         item_count = item_count + 1;
      end
   endfunction

   function void check_result(logic [11:0] idx, logic inl, logic [31:0] res,
                              logic [47:0] cost, logic done);
      if (exp_index.size() == 0) begin
         $error("result beat with no constraint pending");
         errors++;
         return;
      end
      if (idx !== exp_index[0]) begin
         $error("constraint_index exp %0d got %0d", exp_index[0], idx);
         errors++;
      end
      if (inl !== exp_inlier[0]) begin
         $error("is_inlier exp %0d got %0d", exp_inlier[0], inl);
         errors++;
      end
      if (res !== exp_resid[0]) begin
         $error("residual_sq exp %0h got %0h", exp_resid[0], res);
         errors++;
      end
      if (cost !== exp_cost[0]) begin
         $error("total_cost exp %0h got %0h", exp_cost[0], cost);
         errors++;
      end
      if (done !== exp_done[0]) begin
         $error("set_done exp %0d got %0d", exp_done[0], done);
         errors++;
      end
      void'(exp_index.pop_front());
      void'(exp_inlier.pop_front());
      void'(exp_resid.pop_front());
      void'(exp_cost.pop_front());
      void'(exp_done.pop_front());
   endfunction

   function int pending();
      return exp_index.size();
   endfunction
endclass

### sim/tb_msac_range_residual_scorer_unit.sv
`timescale 1ns / 1ps
module tb_msac_range_residual_scorer_unit;

   localparam int CYCLE_LIMIT = 4000000;
   localparam int TAIL_CYCLES = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   bit   hold_rsp = 1'b0;
   bit   long_hold_req = 1'b0;

   msac_req_if req_bus();
   msac_rsp_if rsp_bus();
   msac_csr_if csr_bus();

   msac_cost_scoreboard board = new();

   msac_range_residual_scorer_unit dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Note accepted constraint beats and config writes, and check result beats.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         board.note_constraint(req_bus.tag_x, req_bus.tag_y, req_bus.tag_z,
                               req_bus.anchor_x, req_bus.anchor_y, req_bus.anchor_z,
                               req_bus.measured_range, req_bus.range_deviation,
                               req_bus.final_item);
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         board.check_result(rsp_bus.constraint_index, rsp_bus.is_inlier,
                            rsp_bus.residual_sq, rsp_bus.total_cost, rsp_bus.set_done);
      if (!reset && csr_bus.valid && csr_bus.ready)
         board.write_reg(csr_bus.index, csr_bus.data);
   end

   // Receiver: random stall pattern, always ready when hold_rsp is set, plus a long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_rsp) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   task automatic write_csr(logic [7:0] idx, logic [31:0] val);
      csr_bus.index <= idx;
      csr_bus.data <= val;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_constraint(logic [31:0] tx, ty, tz, ax, ay, az, meas, dev,
                                  logic fin);
      req_bus.tag_x <= tx;
      req_bus.tag_y <= ty;
      req_bus.tag_z <= tz;
      req_bus.anchor_x <= ax;
      req_bus.anchor_y <= ay;
      req_bus.anchor_z <= az;
      req_bus.measured_range <= meas;
      req_bus.range_deviation <= dev;
      req_bus.final_item <= fin;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic idle_req(int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // Drain all expected results, then let the block settle before config.
   task automatic drain();
      idle_req(1);
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Mostly moderate geometry, sometimes full-range values.
   function automatic logic [31:0] pos_val();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      endcase
   endfunction

   task automatic random_constraint(logic fin);
      logic [31:0] meas, dev;
      meas = ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 32'h00C0_0000);
      case ($urandom_range(0, 7))
         0: dev = 0;
         1: dev = $urandom();
         default: dev = $urandom_range(1, 32'h0004_0000);
      endcase
      send_constraint(pos_val(), pos_val(), pos_val(), pos_val(), pos_val(), pos_val(),
                      meas, dev, fin);
   endtask

   task automatic random_phase(int count);
      int left_in_set, burst;
      left_in_set = $urandom_range(1, 12);
      burst = $urandom_range(1, 10);
      for (int i = 0; i < count; i++) begin
         left_in_set--;
         random_constraint(left_in_set == 0 || i == count - 1);
         if (left_in_set == 0) left_in_set = $urandom_range(1, 12);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 10);
            if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 60));
         end
      end
      drain();
   endtask

   initial begin
      logic [31:0] cfg_set[6];
      req_bus.valid = 1'b0;
      req_bus.tag_x = 0;
      req_bus.tag_y = 0;
      req_bus.tag_z = 0;
      req_bus.anchor_x = 0;
      req_bus.anchor_y = 0;
      req_bus.anchor_z = 0;
      req_bus.measured_range = 0;
      req_bus.range_deviation = 0;
      req_bus.final_item = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = msac_pkg::CFG_COS;
      csr_bus.data = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, extremes, zero deviation, far geometry.
      send_constraint(0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b0);
      send_constraint(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 1'b0);
      send_constraint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_constraint(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 1'b0);
      send_constraint(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0,
                      32'h0005_0000, 0, 1'b0);
      send_constraint(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1'b1);
      send_constraint(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 32'h5555_5555,
                      32'hAAAA_AAAA, 0, 32'h0002_8000, 32'h0000_8000, 1'b1);
      drain();

      // Extreme configuration: yaw out of range, max threshold, big translation; then zero threshold.
      write_csr(msac_pkg::CFG_COS, 32'h7FFF_FFFF);
      write_csr(msac_pkg::CFG_SIN, 32'h8000_0000);
      write_csr(msac_pkg::CFG_TRX, 32'h7FFF_FFFF);
      write_csr(msac_pkg::CFG_TRY, 32'h8000_0000);
      write_csr(msac_pkg::CFG_TRZ, 32'hFFFF_FFFF);
      write_csr(msac_pkg::CFG_THR, 32'hFFFF_FFFF);
      for (int i = 0; i < 8; i++) random_constraint(1'b0);
      send_constraint(0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, 1'b1);
      drain();
      write_csr(msac_pkg::CFG_THR, 0);
      write_csr(msac_pkg::CFG_COS, 32'h8000_0000);
      write_csr(msac_pkg::CFG_SIN, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++) random_constraint(i == 5);
      drain();

      // Random phases with varied hypotheses; one long hold-off on results.
      for (int ph = 0; ph < 8; ph++) begin
         cfg_set[0] = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
         cfg_set[1] = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
         cfg_set[2] = pos_val();
         cfg_set[3] = pos_val();
         cfg_set[4] = pos_val();
         cfg_set[5] = ($urandom_range(0, 5) == 0) ? $urandom()
                                                  : $urandom_range(0, 32'h0010_0000);
         if (ph == 7) begin
            cfg_set[0] = msac_pkg::COS_RESET;
            cfg_set[1] = 0;
            cfg_set[5] = msac_pkg::THR_RESET;
         end
         for (int r = 0; r < msac_pkg::CFG_COUNT; r++) write_csr(r[7:0], cfg_set[r]);
         if (ph == 2) long_hold_req = 1'b1;
         hold_rsp = (ph == 5);
         random_phase(200);
      end

      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

### filelist.f
hdl/msac_pkg.sv
hdl/msac_ifs.sv
hdl/msac_mul.sv
hdl/msac_sqrt.sv
hdl/msac_range_residual_scorer_unit.sv
sim/tb_msac_scoreboard.sv
sim/tb_msac_range_residual_scorer_unit.sv
